// ===== hw/rtl/etrl_pkg.sv =====
// Shared types and constants of the edge timestamp record logger.
package etrl_pkg;

    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_TIME  = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    localparam logic CFG_STATUS_PERIOD = 1'b0;
    localparam logic CFG_LOW_WATER     = 1'b1;

    localparam logic [7:0]  EDGE_HDR      = 8'hE1;
    localparam logic [7:0]  STATUS_HDR    = 8'h5A;
    localparam int          EDGE_LEN      = 16;
    localparam logic [31:0] PERIOD_RESET  = 32'd1000000;
    localparam logic [12:0] LOW_WATER_RST = 13'd128;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_EDGE  = 2'd1,
        OP_TIME  = 2'd2,
        OP_DRAIN = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  channel;
        logic        level;
        logic [2:0]  pin_levels;
        logic [31:0] now_us;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PUSH = 5'b00010,
        S_READ = 5'b00100,
        S_DONE = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

endpackage

// ===== hw/rtl/edge_timestamp_record_logger.sv =====
// Top level of the edge timestamp record logger.
// Input channel (i_in_valid / o_in_stall) carries one request per transaction:
// an edge event (channel, new level, microsecond time), a status time check
// (pin levels, time) or a drain of one byte from the record ring.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// request: popped byte and its valid bit, ring fill, overflow flag, drop count.
// An edge packs a 16-byte record and a due time check a 12 + 4*NUM_WIRES byte
// status record into the ring, one byte per cycle through the single ring
// write port; a drain reads one byte through the registered read port.
// From acceptance, a request passes the front-end queue, then the engine states
// S_IDLE, S_PUSH for each record byte or S_READ for a drain, S_DONE and S_HOLD,
// then the result register; the engine takes the next request back in S_IDLE.
// A two-entry queue sits between the request front end and the record engine,
// and a result register lets a finished result wait while the next request is
// taken. While the receiver stalls, the result holds and the engine waits once
// its next result is ready; the queue then fills and o_in_stall rises.
// Configuration writes (period, low-water mark): the user must do them only
// while the block is idle; the block does not enforce it. Synchronous reset
// clears pointers, counters, overflow flag and status deadline, not ring data.
module edge_timestamp_record_logger #(
    parameter int RING_DEPTH = 8192,
    parameter int NUM_WIRES  = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_channel,
    input  logic        i_level,
    input  logic [2:0]  i_pin_levels,
    input  logic [31:0] i_now_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [12:0] o_fill_level,
    output logic        o_overflow_flag,
    output logic [31:0] o_dropped_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import etrl_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    etrl_front #(
        .NUM_WIRES (NUM_WIRES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_channel    (i_channel),
        .i_level      (i_level),
        .i_pin_levels (i_pin_levels),
        .i_now_us     (i_now_us),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    etrl_back #(
        .RING_DEPTH (RING_DEPTH),
        .NUM_WIRES  (NUM_WIRES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_fill_level    (o_fill_level),
        .o_overflow_flag (o_overflow_flag),
        .o_dropped_count (o_dropped_count)
    );
endmodule

// ===== hw/rtl/etrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module etrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/etrl_front.sv =====
// Front end: accept request transactions, classify them and queue them for the back end.
module etrl_front #(
    parameter int NUM_WIRES = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [1:0]           i_channel,
    input  logic                 i_level,
    input  logic [2:0]           i_pin_levels,
    input  logic [31:0]          i_now_us,
    output logic                 o_q_valid,
    output etrl_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);
    import etrl_pkg::*;

    t_item      r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    t_item      cls_item;
    logic       push;
    logic       pop;

    always_comb begin
        cls_item.channel    = i_channel;
        cls_item.level      = i_level;
        cls_item.pin_levels = i_pin_levels;
        cls_item.now_us     = i_now_us;
        case (i_req_type)
            REQ_EDGE: begin
                cls_item.op = (int'(i_channel) < NUM_WIRES) ? OP_EDGE : OP_NOP;
            end
            REQ_TIME:  cls_item.op = OP_TIME;
            REQ_DRAIN: cls_item.op = OP_DRAIN;
            default:   cls_item.op = OP_NOP;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rd];
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wr  = push ? !r_wr : r_wr;
        n_rd  = pop ? !r_rd : r_rd;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= cls_item;
        end
    end
endmodule

// ===== hw/rtl/etrl_back.sv =====
// Back end: per-channel state, record assembly, byte ring and result register.
module etrl_back #(
    parameter int RING_DEPTH = 8192,
    parameter int NUM_WIRES  = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  etrl_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic [12:0]          o_fill_level,
    output logic                 o_overflow_flag,
    output logic [31:0]          o_dropped_count
);
    import etrl_pkg::*;

    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CW         = (PTR_W > 13) ? PTR_W : 13;
    localparam int STATUS_LEN = 12 + 4 * NUM_WIRES;
    localparam int IDX_W      = $clog2(STATUS_LEN);
    localparam int WIDX_W     = IDX_W - 2;

    t_state             r_state, n_state;
    logic [31:0]        r_prev [NUM_WIRES];
    logic [31:0]        n_prev [NUM_WIRES];
    logic [31:0]        r_edges [NUM_WIRES];
    logic [31:0]        n_edges [NUM_WIRES];
    logic [31:0]        r_drop, n_drop;
    logic [15:0]        r_seq, n_seq;
    logic               r_latch, n_latch;
    logic [31:0]        r_due, n_due;
    logic [31:0]        r_period, n_period;
    logic [12:0]        r_low, n_low;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic               r_is_status, n_is_status;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [31:0]        r_w0, n_w0;
    logic [31:0]        r_wa, n_wa;
    logic [31:0]        r_wb, n_wb;
    logic [31:0]        r_w3, n_w3;
    logic [7:0]         r_byte, n_byte;
    logic               r_bvalid, n_bvalid;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_bvalid, n_out_bvalid;
    logic [12:0]        r_out_fill, n_out_fill;
    logic               r_out_flag, n_out_flag;
    logic [31:0]        r_out_drop, n_out_drop;

    logic [31:0]        prv_sel;
    logic [31:0]        cnt_new;
    logic [31:0]        due_diff;
    logic [PTR_W-1:0]   nxt_wp;
    logic [PTR_W-1:0]   nxt_rp;
    logic [PTR_W:0]     fill_ext;
    logic [CW-1:0]      fill_c;
    logic [CW-1:0]      free_c;
    logic               low_hit;
    logic [WIDX_W-1:0]  widx;
    logic [31:0]        word;
    logic [7:0]         wr_byte;
    logic [IDX_W-1:0]   last_idx;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    etrl_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (wr_byte),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        prv_sel = '0;
        cnt_new = '0;
        for (int i = 0; i < NUM_WIRES; i++) begin
            if (int'(i_q_item.channel) == i) begin
                prv_sel = r_prev[i];
                cnt_new = r_edges[i] + 32'd1;
            end
        end
    end

    assign due_diff = i_q_item.now_us - r_due;
    assign nxt_wp   = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign nxt_rp   = (r_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign fill_ext = {1'b0, r_wp} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, r_rp};
    assign fill_c   = (r_wp >= r_rp) ? CW'(r_wp - r_rp) : CW'(fill_ext[PTR_W-1:0]);
    assign free_c   = CW'(RING_DEPTH - 1) - fill_c;
    assign low_hit  = (free_c < CW'(r_low));
    assign widx     = r_idx[IDX_W-1:2];
    assign last_idx = r_is_status ? IDX_W'(STATUS_LEN - 1) : IDX_W'(EDGE_LEN - 1);

    always_comb begin
        word = r_w3;
        if (widx == WIDX_W'(0)) begin
            word = r_w0;
        end else if (widx == WIDX_W'(1)) begin
            word = r_wa;
        end else if (!r_is_status) begin
            word = (widx == WIDX_W'(2)) ? r_wb : r_w3;
        end else begin
            word = r_drop;
            for (int i = 0; i < NUM_WIRES; i++) begin
                if (widx == WIDX_W'(2 + i)) begin
                    word = r_edges[i];
                end
            end
        end
        case (r_idx[1:0])
            2'd0:    wr_byte = word[7:0];
            2'd1:    wr_byte = word[15:8];
            2'd2:    wr_byte = word[23:16];
            default: wr_byte = word[31:24];
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_edges      = r_edges;
        n_drop       = r_drop;
        n_seq        = r_seq;
        n_latch      = r_latch;
        n_due        = r_due;
        n_period     = r_period;
        n_low        = r_low;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_is_status  = r_is_status;
        n_idx        = r_idx;
        n_w0         = r_w0;
        n_wa         = r_wa;
        n_wb         = r_wb;
        n_w3         = r_w3;
        n_byte       = r_byte;
        n_bvalid     = r_bvalid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_fill   = r_out_fill;
        n_out_flag   = r_out_flag;
        n_out_drop   = r_out_drop;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STATUS_PERIOD: n_period = i_cfg_wdata;
                CFG_LOW_WATER:     n_low    = i_cfg_wdata[12:0];
                default:           n_low    = r_low;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_byte   = 8'd0;
                    n_bvalid = 1'b0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    case (i_q_item.op)
                        OP_EDGE: begin
                            for (int i = 0; i < NUM_WIRES; i++) begin
                                if (int'(i_q_item.channel) == i) begin
                                    n_prev[i]  = i_q_item.now_us;
                                    n_edges[i] = cnt_new;
                                end
                            end
                            n_w0 = {7'd0, r_latch, 7'd0, i_q_item.level,
                                    6'd0, i_q_item.channel, EDGE_HDR};
                            n_wa        = i_q_item.now_us - prv_sel;
                            n_wb        = i_q_item.now_us;
                            n_w3        = {cnt_new[15:0], r_seq};
                            n_seq       = r_seq + 16'd1;
                            n_latch     = 1'b0;
                            n_is_status = 1'b0;
                            n_state     = S_PUSH;
                        end
                        OP_TIME: begin
                            if (!due_diff[31]) begin
                                n_w0 = {8'd0, 7'd0, r_latch, 5'd0,
                                        i_q_item.pin_levels, STATUS_HDR};
                                n_wa        = i_q_item.now_us;
                                n_due       = r_due + r_period;
                                n_is_status = 1'b1;
                                n_state     = S_PUSH;
                            end
                        end
                        OP_DRAIN: begin
                            if (r_rp != r_wp) begin
                                ram_re  = 1'b1;
                                n_rp    = nxt_rp;
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH: begin
                if (nxt_wp == r_rp) begin
                    n_drop  = r_drop + 32'd1;
                    n_latch = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_we = 1'b1;
                    n_wp   = nxt_wp;
                    n_idx  = r_idx + 1'b1;
                    if (r_idx == last_idx) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_byte   = ram_rdata;
                n_bvalid = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_latch = r_latch || low_hit;
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_byte;
                    n_out_bvalid = r_bvalid;
                    n_out_fill   = fill_c[12:0];
                    n_out_flag   = r_latch;
                    n_out_drop   = r_drop;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_drop      <= '0;
            r_seq       <= '0;
            r_latch     <= 1'b0;
            r_due       <= PERIOD_RESET;
            r_period    <= PERIOD_RESET;
            r_low       <= LOW_WATER_RST;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WIRES; i++) begin
                r_prev[i]  <= '0;
                r_edges[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_drop      <= n_drop;
            r_seq       <= n_seq;
            r_latch     <= n_latch;
            r_due       <= n_due;
            r_period    <= n_period;
            r_low       <= n_low;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            r_edges     <= n_edges;
        end
        r_is_status  <= n_is_status;
        r_idx        <= n_idx;
        r_w0         <= n_w0;
        r_wa         <= n_wa;
        r_wb         <= n_wb;
        r_w3         <= n_w3;
        r_byte       <= n_byte;
        r_bvalid     <= n_bvalid;
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_fill   <= n_out_fill;
        r_out_flag   <= n_out_flag;
        r_out_drop   <= n_out_drop;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_out_bvalid;
    assign o_fill_level    = r_out_fill;
    assign o_overflow_flag = r_out_flag;
    assign o_dropped_count = r_out_drop;
endmodule

// ===== hw/rtl/etrl_checker.sv =====
// Port-level checks of the edge timestamp record logger and their binding.
module etrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic [12:0] o_fill_level,
    input logic        o_overflow_flag,
    input logic [31:0] o_dropped_count
);
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'd0))
        else $error("nonzero byte without a popped byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_byte) && $stable(o_byte_valid)
         && $stable(o_fill_level) && $stable(o_overflow_flag)
         && $stable(o_dropped_count)))
        else $error("stalled result changed");
endmodule

bind edge_timestamp_record_logger etrl_checker u_etrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_fill_level    (o_fill_level),
    .o_overflow_flag (o_overflow_flag),
    .o_dropped_count (o_dropped_count)
);
